>>> design/gws_pkg.sv
// package for the weighted 3x3 smoother: payload types, constants, fsm states
// no dependencies
`default_nettype none
package gws_pkg;
    localparam int MaxSide  = 256;
    localparam int CoordW   = $clog2(MaxSide);
    localparam int AddrW    = 2 * CoordW;
    localparam int FracBits = 4;
    localparam int SideW    = 9;
    localparam int NumW     = 16 + 17 + 4 + FracBits;   // signed weighted sum, shifted
    localparam int DenW     = 20;
    localparam logic [16:0] WFull = 17'd65536;
    localparam logic [16:0] WDiag = 17'd19195;
    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdQuery = 1'b1;

    typedef struct packed {
        logic             command;
        logic [7:0]       col;
        logic [7:0]       row;
        logic signed [15:0] elevation;
    } t_in;

    typedef struct packed {
        logic signed [19:0] smoothed;
        logic               coord_error;
    } t_out;

    // queued item after classification
    typedef struct packed {
        logic             is_err;
        logic             is_query;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic [SideW-1:0]  side;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_DIV, ST_ROUND, ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> design/gws_front.sv
// front part: accepts items, does loads into the sample memory, queues queries/errors
// depends on gws_pkg
`default_nettype none
module gws_front (
    input  wire logic          i_start,
    input  wire gws_pkg::t_in  i_item,
    input  wire logic [8:0]    i_side,
    input  wire logic          i_q_full,
    input  wire logic          i_inflight,
    output logic               o_busy,
    output logic               o_push,
    output gws_pkg::t_job      o_job,
    output logic               o_wr,
    output logic [gws_pkg::AddrW-1:0] o_wr_addr,
    output logic [15:0]        o_wr_data
);
    import gws_pkg::*;
    logic [SideW-1:0] eff;
    logic             bad, acc;

    assign eff   = (i_side > SideW'(MaxSide)) ? SideW'(MaxSide) : i_side;
    assign bad   = ({1'b0, i_item.col} >= eff) || ({1'b0, i_item.row} >= eff);
    // a load waits until no earlier beat is queued or being worked on
    assign o_busy = i_q_full || (i_inflight && i_item.command == CmdLoad);
    assign acc   = i_start && !o_busy;

    assign o_wr      = acc && !bad && (i_item.command == CmdLoad);
    assign o_wr_addr = {i_item.row, i_item.col};
    assign o_wr_data = i_item.elevation;
    assign o_push    = acc && (bad || i_item.command == CmdQuery);
    assign o_job     = '{is_err: bad, is_query: i_item.command == CmdQuery,
                         col: i_item.col, row: i_item.row, side: eff};
endmodule
`default_nettype wire

>>> design/gws_queue.sv
// two-entry queue between front and back parts
// depends on gws_pkg
`default_nettype none
module gws_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gws_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output gws_pkg::t_job      o_job
);
    import gws_pkg::*;
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count");
endmodule
`default_nettype wire

>>> design/gws_back.sv
// back part: reads nine cells for a query, accumulates weighted sum, divides by
// restoring steps; an error item skips to the output; depends on gws_pkg
`default_nettype none
module gws_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire gws_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_idle,
    output logic [gws_pkg::AddrW-1:0] o_rd_addr,
    input  wire logic [15:0]   i_rd_data,
    output logic               o_valid,
    output gws_pkg::t_out      o_result
);
    import gws_pkg::*;
    localparam int QW = NumW;
    t_state r_state, n_state;
    t_job   r_job;
    logic [3:0] r_k;           // neighbour being addressed
    logic       r_rv, r_rdiag; // read data valid next cycle
    logic signed [NumW-1:0] r_num;
    logic [DenW-1:0] r_den;
    logic [NumW:0]   r_rem;
    logic [QW-1:0]   r_q, r_mag;
    logic [5:0]      r_bit;
    logic            r_neg;
    t_out            r_out;
    logic            r_valid;

    logic signed [2:0] dc, dr;
    logic signed [9:0] nc, nr;
    logic in_grid, diag;
    logic [NumW:0] trial;

    // neighbour offsets, row by row from the upper left
    always_comb begin
        case (r_k)
            4'd0, 4'd3, 4'd6: dc = -3'sd1;
            4'd1, 4'd4, 4'd7: dc = 3'sd0;
            default:          dc = 3'sd1;
        endcase
        case (r_k)
            4'd0, 4'd1, 4'd2: dr = -3'sd1;
            4'd3, 4'd4, 4'd5: dr = 3'sd0;
            default:          dr = 3'sd1;
        endcase
    end

    assign nc = signed'({2'b0, r_job.col}) + 10'(dc);
    assign nr = signed'({2'b0, r_job.row}) + 10'(dr);
    assign in_grid = nc >= 0 && nr >= 0 && nc < signed'({1'b0, r_job.side})
                     && nr < signed'({1'b0, r_job.side}) && r_k < 4'd9;
    assign diag = dc != 0 && dr != 0;
    assign o_rd_addr = {nr[CoordW-1:0], nc[CoordW-1:0]};
    assign trial = {r_rem[NumW-1:0], r_mag[QW-1]};
    assign o_idle = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                n_state = (i_job.is_err || !i_job.is_query) ? ST_OUT : ST_READ;
            end
            ST_READ:  if (r_k == 4'd9 && !r_rv) n_state = ST_DIV;
            ST_DIV:   if (r_bit == 6'd0) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_valid <= 1'b0; r_rv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_job <= i_job; r_k <= 4'd0; r_rv <= 1'b0;
                    r_num <= '0; r_den <= '0;
                    r_out <= '{smoothed: '0, coord_error: i_job.is_err};
                end
                ST_READ: begin
                    r_rv <= 1'b0;
                    if (r_k != 4'd9) begin
                        r_k <= r_k + 4'd1;
                        r_rv <= in_grid; r_rdiag <= diag;
                        if (in_grid) r_den <= r_den + DenW'(diag ? WDiag : WFull);
                    end
                    if (r_rv) r_num <= r_num + NumW'(signed'(i_rd_data) *
                        signed'({1'b0, r_rdiag ? WDiag : WFull}));
                    if (r_k == 4'd9 && !r_rv) begin
                        // magnitude times 2^(frac+1) plus den; divide by 2*den
                        r_neg <= r_num < 0;
                        r_mag <= (((r_num < 0) ? QW'(-r_num) : QW'(r_num)) << (FracBits + 1))
                                 + QW'(r_den);
                        r_rem <= '0; r_q <= '0; r_bit <= 6'(QW);
                    end
                end
                ST_DIV: if (r_bit != 6'd0) begin
                    r_bit <= r_bit - 6'd1;
                    r_mag <= r_mag << 1;
                    if (trial >= {r_den, 1'b0}) begin
                        r_rem <= trial - (NumW+1)'({r_den, 1'b0});
                        r_q <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_q <= {r_q[QW-2:0], 1'b0};
                    end
                end
                ST_ROUND: begin
                    if (r_q > QW'(524287) && !r_neg) r_out.smoothed <= 20'sd524287;
                    else if (r_q > QW'(524288)) r_out.smoothed <= -20'sd524288;
                    else if (r_neg) r_out.smoothed <= 20'(-r_q);
                    else r_out.smoothed <= 20'(r_q);
                end
                ST_OUT: r_valid <= r_job.is_err || r_job.is_query;
                default: ;
            endcase
        end
    end
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.coord_error) |-> o_result.smoothed == '0)
        else $error("error result not zero");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_den != '0) else $error("zero divisor");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
endmodule
`default_nettype wire

>>> design/grid_weighted_3x3_smoother.sv
// Weighted 3x3 smoother over a 256x256 grid of signed 16-bit samples. A load is
// written in the cycle it is accepted, but busy holds a load off while a query or
// an error beat is still queued or in the back part, so a query never sees a later
// load; busy also rises when the two-entry queue to the back part is full. The back
// part reads the nine cells one a cycle, divides with a restoring divider one bit
// a cycle and rounds the quotient, and only then shows a query result on
// o_result_valid; a bad coordinate skips the reads, the divider and the rounding.
// Results appear for one cycle and cannot be held off.
// Cells must be loaded before they are queried.
// depends on gws_pkg, gws_front, gws_queue, gws_back
`default_nettype none
module grid_weighted_3x3_smoother (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire gws_pkg::t_in i_item,
    input  wire logic         i_cfg_we,
    input  wire logic [8:0]   i_cfg_data,
    output logic              o_result_valid,
    output gws_pkg::t_out     o_result
);
    import gws_pkg::*;
    logic [SideW-1:0] r_side;
    logic push, pop, full, empty, wr;
    logic back_idle, inflight;
    t_job job_in, job_out;
    logic [AddrW-1:0] wa, ra;
    logic [15:0] wd, r_rd;
    logic [15:0] mem [MaxSide*MaxSide];

    assign inflight = !empty || !back_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_side <= 9'd256;
        else if (i_cfg_we) r_side <= i_cfg_data;
    end
    always_ff @(posedge i_clk) begin
        if (wr) mem[wa] <= wd;
        r_rd <= mem[ra];
    end

    gws_front u_front (.i_start(start), .i_item, .i_side(r_side),
        .i_q_full(full), .i_inflight(inflight), .o_busy(busy), .o_push(push),
        .o_job(job_in), .o_wr(wr), .o_wr_addr(wa), .o_wr_data(wd));
    gws_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_job(job_out));
    gws_back u_back (.i_clk, .i_rst_n, .i_empty(empty), .i_job(job_out), .o_pop(pop),
        .o_idle(back_idle), .o_rd_addr(ra), .i_rd_data(r_rd),
        .o_valid(o_result_valid), .o_result);
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for grid_weighted_3x3_smoother: directed and random loads and queries,
// scoreboard with its own weighted-mean predictor; depends on gws_pkg and the rtl
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gws_pkg::*;

    localparam int SIDE_MAX   = 256;
    localparam int WATCH_LIM  = 20000;
    localparam int DRAIN_WAIT = 100;

    class smoother_scoreboard;
        logic signed [15:0] cells [0:SIDE_MAX*SIDE_MAX-1];
        int unsigned side = 256;
        t_out pending_means[$];
        int mismatches, loads, queries, coord_errs;

        function int unsigned eff_side();
            return (side < SIDE_MAX) ? side : SIDE_MAX;
        endfunction

        function logic signed [19:0] weighted_mean(int c, int r);
            longint num;
            longint unsigned den, mag, quo;
            longint res;
            int nc, nr;
            bit neg;
            num = 0;
            den = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    longint w;
                    nc = c + dc;
                    nr = r + dr;
                    if (nc < 0 || nr < 0 || nc >= eff_side() || nr >= eff_side()) continue;
                    w = (dc != 0 && dr != 0) ? longint'(WDiag) : longint'(WFull);
                    num += longint'(cells[nr*SIDE_MAX+nc]) * w;
                    den += w;
                end
            end
            neg = num < 0;
            mag = neg ? longint'(-num) : num;
            mag = mag << FracBits;
            quo = (2*mag + den) / (2*den);
            res = neg ? -longint'(quo) : longint'(quo);
            if (res > 524287) res = 524287;
            if (res < -524288) res = -524288;
            return res[19:0];
        endfunction

        function void note_input(t_in it);
            t_out e;
            if (it.col >= eff_side() || it.row >= eff_side()) begin
                e.smoothed = '0;
                e.coord_error = 1'b1;
                pending_means.push_back(e);
                coord_errs++;
            end else if (it.command == CmdLoad) begin
                cells[it.row*SIDE_MAX+it.col] = it.elevation;
                loads++;
            end else begin
                e.smoothed = weighted_mean(it.col, it.row);
                e.coord_error = 1'b0;
                pending_means.push_back(e);
                queries++;
            end
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result smoothed=%0d err=%0b",
                         $time, got.smoothed, got.coord_error);
                mismatches++;
                return;
            end
            e = pending_means.pop_front();
            if (got.smoothed !== e.smoothed) begin
                $display("%0t: smoothed expected %0d actual %0d",
                         $time, e.smoothed, got.smoothed);
                mismatches++;
            end
            if (got.coord_error !== e.coord_error) begin
                $display("%0t: coord_error expected %0b actual %0b",
                         $time, e.coord_error, got.coord_error);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, i_cfg_we, o_result_valid;
    logic [8:0] i_cfg_data;
    t_in  i_item;
    t_out o_result;

    smoother_scoreboard sb = new();
    bit loaded [0:SIDE_MAX*SIDE_MAX-1];
    int idle_pct;
    int quiet_cycles;

    grid_weighted_3x3_smoother uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    // no beat in either direction for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIM) begin
            $display("timeout at %0t", $time);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(t_in it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
        if (it.command == CmdLoad && it.col < sb.eff_side() && it.row < sb.eff_side())
            loaded[it.row*SIDE_MAX+it.col] = 1'b1;
    endtask

    // a query first gets unloaded in-grid neighbours loaded, with its elevation or, one time in four, a random one
    task automatic issue(t_in it);
        t_in fill;
        int nc, nr;
        bit gap;
        if (it.command == CmdQuery && it.col < sb.eff_side() && it.row < sb.eff_side()) begin
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nc = it.col + dc;
                    nr = it.row + dr;
                    gap = nc >= 0 && nr >= 0 && nc < sb.eff_side() && nr < sb.eff_side();
                    if (gap && !loaded[nr*SIDE_MAX+nc]) begin
                        fill.command = CmdLoad;
                        fill.col = 8'(nc);
                        fill.row = 8'(nr);
                        fill.elevation = ($urandom_range(3) == 0) ? 16'($urandom)
                                                                : it.elevation;
                        send_beat(fill);
                    end
                end
            end
        end
        send_beat(it);
    endtask

    task automatic set_side(int unsigned v);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_means.size() != 0);
        // loads give no result, so let the pipe drain
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 9'(v);
        @(posedge i_clk);
        sb.side = v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in make_item(logic cmd, int c, int r, int e);
        t_in it;
        it.command = cmd;
        it.col = 8'(c);
        it.row = 8'(r);
        it.elevation = 16'(e);
        return it;
    endfunction

    function automatic int pick_coord();
        int eff, base;
        eff = sb.eff_side();
        case ($urandom_range(9))
            0: return $urandom_range(255);
            1, 2: base = 0;
            3, 4: base = (eff > 4) ? eff - 4 : 0;
            default: base = (eff > 4) ? $urandom_range(eff - 4) : 0;
        endcase
        return (base + $urandom_range(4)) & 8'hff;
    endfunction

    initial begin
        int unsigned sides [9];
        int pcts [3];
        sides = '{2, 5, 1, 0, 17, 511, 3, 300, 64};
        pcts = '{0, 58, 15};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_item <= '0;
        idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners and inner cells of the full grid with extreme elevations, ties and mixed signs, then a grid of side 2
        issue(make_item(CmdQuery, 0, 0, 32767));
        issue(make_item(CmdQuery, 255, 255, -32768));
        issue(make_item(CmdQuery, 255, 0, 16'h5555));
        issue(make_item(CmdQuery, 0, 255, 16'haaaa));
        issue(make_item(CmdLoad, 128, 128, -1));
        issue(make_item(CmdQuery, 128, 128, 1));
        issue(make_item(CmdQuery, 127, 128, -32768));
        issue(make_item(CmdQuery, 254, 254, 0));
        issue(make_item(CmdQuery, 1, 1, 32767));
        set_side(2);
        issue(make_item(CmdQuery, 1, 1, 0));
        issue(make_item(CmdLoad, 2, 0, 7));
        issue(make_item(CmdQuery, 0, 255, 0));
        issue(make_item(CmdLoad, 255, 255, 0));
        issue(make_item(CmdQuery, 1, 0, 0));

        for (int ph = 0; ph < 9; ph++) begin
            set_side(sides[ph]);
            idle_pct = pcts[ph % 3];
            for (int n = 0; n < 40; n++)
                issue(make_item($urandom_range(1), pick_coord(), pick_coord(), $urandom));
        end
        set_side(256);
        idle_pct = 15;
        for (int n = 0; n < 20; n++)
            issue(make_item($urandom_range(1), pick_coord(), pick_coord(), $urandom));

        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_means.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d loads, %0d queries, %0d coordinate errors",
                 sb.loads, sb.queries, sb.coord_errs);
        $display("across grid sides from 0 up to beyond the largest grid");
        if (sb.mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

>>> grid_weighted_3x3_smoother.f
design/gws_pkg.sv
design/gws_front.sv
design/gws_queue.sv
design/gws_back.sv
design/grid_weighted_3x3_smoother.sv
tb/sv/tb.sv
